// ===== design/lcd_line_timing_and_stat_irq_core_defines.svh =====
// Assertion macros shared by the checker of the LCD line timing core.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef LCD_LINE_TIMING_AND_STAT_IRQ_CORE_DEFINES_SVH
`define LCD_LINE_TIMING_AND_STAT_IRQ_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LSTI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LSTI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/lsti_pkg.sv =====
// Shared types and constants of the LCD line timing and STAT interrupt core.
// No dependencies; the front, queue, back and top level refer to it by scoped names.
package lsti_pkg;

	// Line timing
	parameter int LINE_CYCLES   = 456;
	parameter int VISIBLE_LINES = 144;
	parameter int OAM_END       = 80;
	parameter int HBLANK_START  = 80 + 172;
	parameter int LAST_LINE     = 153;

	// Depth of the queue between front and back
	parameter int QUEUE_DEPTH = 2;

	// Request codes on req_type
	parameter logic [1:0] REQ_TICK  = 2'd0;
	parameter logic [1:0] REQ_READ  = 2'd1;
	parameter logic [1:0] REQ_WRITE = 2'd2;

	// Register selects on reg_sel
	parameter logic [1:0] SEL_LCDC = 2'd0;
	parameter logic [1:0] SEL_STAT = 2'd1;
	parameter logic [1:0] SEL_LY   = 2'd2;
	parameter logic [1:0] SEL_LYC  = 2'd3;

	// STAT and LCDC bit positions
	parameter logic [7:0] STAT_WR_MASK = 8'hF8;
	parameter int STAT_HBLANK_EN = 3;
	parameter int STAT_VBLANK_EN = 4;
	parameter int STAT_OAM_EN    = 5;
	parameter int STAT_LYC_EN    = 6;
	parameter int STAT_COINC     = 2;
	parameter int LCDC_ENABLE    = 7;

	// STAT modes
	parameter logic [1:0] MODE_HBLANK = 2'd0;
	parameter logic [1:0] MODE_VBLANK = 2'd1;
	parameter logic [1:0] MODE_OAM    = 2'd2;
	parameter logic [1:0] MODE_DRAW   = 2'd3;

	// Operation class assigned by the front
	typedef enum logic [1:0] {
		OP_TICK,
		OP_READ,
		OP_WRITE,
		OP_NONE
	} op_t;

	// One decoded beat held in the queue
	typedef struct packed {
		op_t        op;
		logic [8:0] cycles;
		logic [1:0] sel;
		logic [7:0] data;
	} entry_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// ===== design/lsti_front.sv =====
// Front of the LCD line timing core: accepts input beats and classifies them.
// Depends on lsti_pkg; feeds lsti_queue.
module lsti_front (
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             req_type,
	input  logic [8:0]             cycles,
	input  logic [1:0]             reg_sel,
	input  logic [7:0]             wr_data,
	input  lsti_pkg::queue_status_t q_status,
	output logic                   push,
	output lsti_pkg::entry_t       push_entry
);

	// The front holds off only while the queue is full.
	assign in_stall = q_status.full;
	assign push     = in_valid && !q_status.full;

	// Classify the request; unused codes become a no-op.
	always_comb begin
		push_entry.cycles = cycles;
		push_entry.sel    = reg_sel;
		push_entry.data   = wr_data;
		case (req_type)
			lsti_pkg::REQ_TICK:  push_entry.op = lsti_pkg::OP_TICK;
			lsti_pkg::REQ_READ:  push_entry.op = lsti_pkg::OP_READ;
			lsti_pkg::REQ_WRITE: push_entry.op = lsti_pkg::OP_WRITE;
			default:             push_entry.op = lsti_pkg::OP_NONE;
		endcase
	end

endmodule

// ===== design/lsti_queue.sv =====
// Short FIFO of decoded beats between the front and the back.
// Depends on lsti_pkg for the entry and status types.
module lsti_queue #(
	parameter int DEPTH = lsti_pkg::QUEUE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  lsti_pkg::entry_t        push_entry,
	input  logic                    pop,
	output lsti_pkg::entry_t        head,
	output lsti_pkg::queue_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lsti_pkg::entry_t   slots_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign head         = slots_q[rd_ptr_q];
	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage; no reset needed for payload.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ===== design/lsti_back.sv =====
// Back of the LCD line timing core: holds the timing and register state,
// carries out one queued beat per cycle while the output is not stalled
// and registers the result beat. Depends on lsti_pkg; drains lsti_queue.
module lsti_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lsti_pkg::entry_t        head,
	input  lsti_pkg::queue_status_t q_status,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [7:0]              rd_data,
	output logic                    vblank_irq,
	output logic                    irq_lcd_stat
);

	logic [8:0] line_cycle_q;
	logic [7:0] line_number_q;
	logic [7:0] status_bits_q;
	logic [7:0] lcd_control_q;
	logic [7:0] compare_line_q;

	logic       out_valid_q;
	logic [7:0] rd_data_q;
	logic       vblank_irq_q;
	logic       irq_lcd_stat_q;

	logic [9:0] pos_sum;
	logic [9:0] pos_wrap;
	logic       line_change;
	logic [8:0] pos_next;
	logic [7:0] line_inc;
	logic [7:0] line_next;
	logic       was_hblank;
	logic       vbl_raw;
	logic       stat_raw;
	logic       lcd_on;
	logic [1:0] mode;
	logic [7:0] stat_value;
	logic [7:0] rd_value;

	// Take a beat whenever the output register is free or being emptied.
	assign pop = !q_status.empty && (!out_valid_q || !out_stall);

	// Position within the line after a tick, with at most one line change.
	assign pos_sum     = {1'b0, line_cycle_q} + {1'b0, head.cycles};
	assign pos_wrap    = pos_sum - 10'(lsti_pkg::LINE_CYCLES);
	assign line_change = (pos_sum >= 10'(lsti_pkg::LINE_CYCLES));
	always_comb begin
		if (!line_change) begin
			pos_next = pos_sum[8:0];
		end else if (pos_wrap >= 10'(lsti_pkg::LINE_CYCLES)) begin
			pos_next = 9'(lsti_pkg::LINE_CYCLES - 1);
		end else begin
			pos_next = pos_wrap[8:0];
		end
	end

	// Next line number, wrapping after the last line.
	assign line_inc  = line_number_q + 8'd1;
	assign line_next = (line_inc > 8'(lsti_pkg::LAST_LINE)) ? 8'd0 : line_inc;

	// Interrupt sources raised by a tick.
	assign was_hblank = (line_cycle_q >= 9'(lsti_pkg::HBLANK_START));
	assign lcd_on     = lcd_control_q[lsti_pkg::LCDC_ENABLE];
	always_comb begin
		vbl_raw  = 1'b0;
		stat_raw = 1'b0;
		if (line_change) begin
			if (line_next == 8'(lsti_pkg::VISIBLE_LINES)) begin
				vbl_raw = 1'b1;
				if (status_bits_q[lsti_pkg::STAT_VBLANK_EN]) begin
					stat_raw = 1'b1;
				end
			end
			if (line_next < 8'(lsti_pkg::VISIBLE_LINES)
				&& status_bits_q[lsti_pkg::STAT_OAM_EN]) begin
				stat_raw = 1'b1;
			end
			if (line_next == compare_line_q && status_bits_q[lsti_pkg::STAT_LYC_EN]) begin
				stat_raw = 1'b1;
			end
		end else if (line_number_q < 8'(lsti_pkg::VISIBLE_LINES)) begin
			if (pos_next >= 9'(lsti_pkg::HBLANK_START) && !was_hblank
				&& status_bits_q[lsti_pkg::STAT_HBLANK_EN]) begin
				stat_raw = 1'b1;
			end
		end
	end

	// STAT read value: enables, coincidence flag and current mode.
	always_comb begin
		if (line_number_q >= 8'(lsti_pkg::VISIBLE_LINES)) begin
			mode = lsti_pkg::MODE_VBLANK;
		end else if (line_cycle_q < 9'(lsti_pkg::OAM_END)) begin
			mode = lsti_pkg::MODE_OAM;
		end else if (line_cycle_q < 9'(lsti_pkg::HBLANK_START)) begin
			mode = lsti_pkg::MODE_DRAW;
		end else begin
			mode = lsti_pkg::MODE_HBLANK;
		end
		stat_value = status_bits_q;
		stat_value[lsti_pkg::STAT_COINC] = status_bits_q[lsti_pkg::STAT_COINC]
			| (line_number_q == compare_line_q);
		stat_value[1:0] = status_bits_q[1:0] | mode;
	end

	// Register read mux.
	always_comb begin
		case (head.sel)
			lsti_pkg::SEL_LCDC: rd_value = lcd_control_q;
			lsti_pkg::SEL_STAT: rd_value = stat_value;
			lsti_pkg::SEL_LY:   rd_value = line_number_q;
			lsti_pkg::SEL_LYC:  rd_value = compare_line_q;
			default:            rd_value = compare_line_q;
		endcase
	end

	// Timing and register state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_cycle_q   <= '0;
			line_number_q  <= '0;
			status_bits_q  <= '0;
			lcd_control_q  <= '0;
			compare_line_q <= '0;
		end else if (pop) begin
			case (head.op)
				lsti_pkg::OP_TICK: begin
					line_cycle_q <= pos_next;
					if (line_change) begin
						line_number_q <= line_next;
					end
				end
				lsti_pkg::OP_WRITE: begin
					case (head.sel)
						lsti_pkg::SEL_LCDC: lcd_control_q  <= head.data;
						lsti_pkg::SEL_STAT: status_bits_q  <= head.data & lsti_pkg::STAT_WR_MASK;
						lsti_pkg::SEL_LYC:  compare_line_q <= head.data;
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// Result beat valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result beat payload, loaded with each taken beat.
	always_ff @(posedge clk) begin
		if (pop) begin
			rd_data_q      <= (head.op == lsti_pkg::OP_READ) ? rd_value : 8'd0;
			vblank_irq_q   <= (head.op == lsti_pkg::OP_TICK) && vbl_raw && lcd_on;
			irq_lcd_stat_q <= (head.op == lsti_pkg::OP_TICK) && stat_raw && lcd_on;
		end
	end

	assign out_valid    = out_valid_q;
	assign rd_data      = rd_data_q;
	assign vblank_irq   = vblank_irq_q;
	assign irq_lcd_stat = irq_lcd_stat_q;

endmodule

// ===== design/lcd_line_timing_and_stat_irq_core.sv =====
// Top level of the LCD line timing and STAT interrupt core.
// Depends on lsti_pkg, lsti_front, lsti_queue and lsti_back.
//
//   Channel  Handshake            Beat contents
//   input    in_valid / in_stall  req_type, cycles, reg_sel, wr_data
//   output   out_valid/out_stall  rd_data, vblank_irq, irq_lcd_stat
//
// One beat per clock is sustained unless the output stalls; an accepted beat
// is written into the queue and from there taken by the back into the output
// register (the back updates all timing state in one step).
// Asynchronous active-low reset clears all timing and register state.
// in_stall rises only while the queue is full; a stalled output keeps its beat
// while the front goes on filling the queue.
module lcd_line_timing_and_stat_irq_core #(
	parameter int QUEUE_DEPTH = lsti_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [8:0] cycles,
	input  logic [1:0] reg_sel,
	input  logic [7:0] wr_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] rd_data,
	output logic       vblank_irq,
	output logic       irq_lcd_stat
);

	lsti_pkg::queue_status_t q_status;
	lsti_pkg::entry_t        push_entry;
	lsti_pkg::entry_t        head;
	logic                    push;
	logic                    pop;

	// Accept and classify.
	lsti_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.cycles     (cycles),
		.reg_sel    (reg_sel),
		.wr_data    (wr_data),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	// Decouple the two sides.
	lsti_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	// Execute and deliver.
	lsti_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.rd_data      (rd_data),
		.vblank_irq   (vblank_irq),
		.irq_lcd_stat (irq_lcd_stat)
	);

endmodule

// ===== design/lsti_checker.sv =====
// Port-level checker for the LCD line timing core, bound to the top level.
// Depends on lcd_line_timing_and_stat_irq_core_defines.svh for its macros.
`include "lcd_line_timing_and_stat_irq_core_defines.svh"

module lsti_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] rd_data,
	input logic       vblank_irq,
	input logic       irq_lcd_stat
);

	// A stalled result beat stays in place.
	`LSTI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(rd_data) && $stable(vblank_irq) && $stable(irq_lcd_stat), "stalled result beat changed")

	// Interrupts come only from ticks, which read back zero.
	`LSTI_ASSERT_NOW(a_irq_no_data, out_valid && (vblank_irq || irq_lcd_stat), rd_data == 8'h00, "interrupt beat carries read data")

	// VBlank needs a full frame of line changes, so two in a row are impossible.
	`LSTI_ASSERT_NEXT(a_vblank_spacing, out_valid && !out_stall && vblank_irq, !(out_valid && vblank_irq), "back to back vblank beats")

endmodule

bind lcd_line_timing_and_stat_irq_core lsti_checker u_lsti_checker (.*);
